// ===== hw/rtl/mouse_button_click_tracker_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MOUSE_BUTTON_CLICK_TRACKER_CORE_MACROS_SVH
`define MOUSE_BUTTON_CLICK_TRACKER_CORE_MACROS_SVH

// Assertion that is switched off while reset is held.
`define MBCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define MBCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mbct_pkg.sv =====
`default_nettype none

package mbct_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int COORD_BITS  = 12;
    localparam int TIME_W      = 32;
    localparam int FLAG_W      = 4 * NUM_BUTTONS;
    localparam int RECT_W      = 4 * COORD_BITS;
    localparam int IN_W        = 64;
    localparam int OUT_W       = 160;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DBL_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [TIME_W-1:0]     RST_DBL_MS = 32'd500;
    localparam logic [COORD_BITS-1:0] RST_WIDTH  = 12'd1024;
    localparam logic [COORD_BITS-1:0] RST_HEIGHT = 12'd768;

    typedef struct packed {
        logic [IN_W-TIME_W-NUM_BUTTONS-2*COORD_BITS-2:0] pad;
        logic [TIME_W-1:0]       time_ms;
        logic [NUM_BUTTONS-1:0]  buttons_now;
        logic [COORD_BITS-1:0]   pointer_y;
        logic [COORD_BITS-1:0]   pointer_x;
        logic                    window_active;
    } t_tick;

    typedef struct packed {
        logic [COORD_BITS-1:0] end_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] start_x;
    } t_rect;

endpackage

`default_nettype wire

// ===== hw/rtl/mouse_button_click_tracker_core.sv =====
// Mouse button click tracker. One tick beat is taken per clock cycle while the result side takes
// beats, and each tick gives exactly one result beat: the tick is registered, the edge, double-click
// and drag-rectangle logic is combinational, and the result is registered. While the
// result beat is stalled, one further tick is held in the input register before the slave
// side stops taking beats. Configuration writes are taken in any cycle and should only be
// made while no tick is in flight.
`default_nettype none

module mouse_button_click_tracker_core
    import mbct_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // window_active, pointer_x, pointer_y, buttons_now, time_ms, zero pad
    input  wire  [IN_W-1:0]       i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // button_flags, left_drag_rect, middle_drag_rect, right_drag_rect, zero pad
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    logic [TIME_W-1:0]     r_dbl_ms;
    logic [COORD_BITS-1:0] r_width;
    logic [COORD_BITS-1:0] r_height;

    logic  r_in_valid;
    t_tick r_in;
    logic  r_out_valid;
    logic [OUT_W-1:0] r_out;

    logic [FLAG_W-1:0] r_flag;
    logic [TIME_W-1:0] r_last [NUM_BUTTONS];
    t_rect             r_rect [NUM_BUTTONS];

    logic [FLAG_W-1:0] n_flag;
    logic [TIME_W-1:0] n_last [NUM_BUTTONS];
    t_rect             n_rect [NUM_BUTTONS];

    logic                   advance;
    logic                   take;
    logic                   in_area;
    logic [NUM_BUTTONS-1:0] old_held;
    logic [NUM_BUTTONS-1:0] press;
    logic [NUM_BUTTONS-1:0] release_e;
    logic [NUM_BUTTONS-1:0] dbl;
    logic [TIME_W-1:0]      limit [NUM_BUTTONS];

    assign o_cfg_ready     = 1'b1;
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign take            = r_in_valid && advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // Signed coordinates: a set sign bit is outside, otherwise compare the magnitude.
    assign in_area = !r_in.pointer_x[COORD_BITS-1] && !r_in.pointer_y[COORD_BITS-1] &&
                     ({1'b0, r_in.pointer_x[COORD_BITS-2:0]} < r_width) &&
                     ({1'b0, r_in.pointer_y[COORD_BITS-2:0]} < r_height);

    assign old_held  = r_flag[NUM_BUTTONS-1:0];
    assign press     = r_in.buttons_now & ~old_held;
    assign release_e = old_held & ~r_in.buttons_now;

    always_comb begin
        n_flag = r_flag;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            limit[b]  = r_last[b] + r_dbl_ms;
            dbl[b]    = release_e[b] && (r_in.time_ms < limit[b]);
            n_last[b] = r_last[b];
            n_rect[b] = r_rect[b];
        end
        if (r_in.window_active && in_area) begin
            n_flag = {dbl, release_e, press, r_in.buttons_now};
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (release_e[b]) begin
                    n_last[b] = r_in.time_ms;
                end
                if (r_in.buttons_now[b]) begin
                    n_rect[b].end_x = r_in.pointer_x;
                    n_rect[b].end_y = r_in.pointer_y;
                end
                if (press[b]) begin
                    n_rect[b].start_x = r_in.pointer_x;
                    n_rect[b].start_y = r_in.pointer_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbl_ms <= RST_DBL_MS;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DBL_MS: r_dbl_ms <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[COORD_BITS-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flag      <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_last[b] <= '0;
                r_rect[b] <= '0;
            end
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (take) begin
                r_flag <= n_flag;
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    r_last[b] <= n_last[b];
                    r_rect[b] <= n_rect[b];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= t_tick'(i_s_axis_tdata);
        end
        if (take) begin
            r_out <= {(OUT_W - FLAG_W - NUM_BUTTONS * RECT_W)'(0),
                      n_rect[2], n_rect[1], n_rect[0], n_flag};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbct_checker.sv =====
`default_nettype none
`include "mouse_button_click_tracker_core_macros.svh"

module mbct_checker
    import mbct_pkg::*;
(
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_m_axis_tvalid,
    input wire             i_m_axis_tready,
    input wire [OUT_W-1:0] o_m_axis_tdata
);

    logic [NUM_BUTTONS-1:0] held;
    logic [NUM_BUTTONS-1:0] press;
    logic [NUM_BUTTONS-1:0] rel;
    logic [NUM_BUTTONS-1:0] dbl;

    assign held  = o_m_axis_tdata[NUM_BUTTONS-1:0];
    assign press = o_m_axis_tdata[2*NUM_BUTTONS-1:NUM_BUTTONS];
    assign rel   = o_m_axis_tdata[3*NUM_BUTTONS-1:2*NUM_BUTTONS];
    assign dbl   = o_m_axis_tdata[4*NUM_BUTTONS-1:3*NUM_BUTTONS];

    `MBCT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result beat after reset")
    `MBCT_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "stalled result beat dropped")
    `MBCT_ASSERT(a_press_held, i_clk, i_rst_n, o_m_axis_tvalid |-> ((press & ~held) == '0) && ((rel & held) == '0), "edge flags disagree with held flags")
    `MBCT_ASSERT(a_dbl_release, i_clk, i_rst_n, o_m_axis_tvalid |-> ((dbl & ~rel) == '0), "double click without release")

endmodule

bind mouse_button_click_tracker_core mbct_checker u_mbct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
    import mbct_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_ITEMS = 115;
    localparam int NO_AREA_ITEMS = 40;

    typedef struct packed {
        logic [OUT_W-FLAG_W-3*RECT_W-1:0] pad;
        t_rect                            right;
        t_rect                            middle;
        t_rect                            left;
        logic [FLAG_W-1:0]                flags;
    } t_report;

    class click_tracker_board;
        logic [TIME_W-1:0]      dbl_window;
        logic [COORD_BITS-1:0]  area_w;
        logic [COORD_BITS-1:0]  area_h;
        logic [FLAG_W-1:0]      flags;
        logic [TIME_W-1:0]      last_release [NUM_BUTTONS];
        t_rect                  rects [NUM_BUTTONS];
        t_report                expected_reports [$];
        int                     errors;

        function new();
            dbl_window = RST_DBL_MS;
            area_w = RST_WIDTH;
            area_h = RST_HEIGHT;
            flags = '0;
            foreach (last_release[b]) begin
                last_release[b] = '0;
                rects[b] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DBL_MS: begin
                    dbl_window = val;
                end
                CFG_WIDTH: begin
                    area_w = val[COORD_BITS-1:0];
                end
                CFG_HEIGHT: begin
                    area_h = val[COORD_BITS-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void absorb_tick(t_tick tk);
            int px;
            int py;
            logic [NUM_BUTTONS-1:0] held;
            logic [NUM_BUTTONS-1:0] press;
            logic [NUM_BUTTONS-1:0] rel;
            logic [NUM_BUTTONS-1:0] dbl;
            logic [TIME_W-1:0] limit;
            t_report rep;
            px = $signed(tk.pointer_x);
            py = $signed(tk.pointer_y);
            if (tk.window_active && px >= 0 && py >= 0 &&
                    px < int'(area_w) && py < int'(area_h)) begin
                held = flags[NUM_BUTTONS-1:0];
                press = tk.buttons_now & ~held;
                rel = held & ~tk.buttons_now;
                dbl = '0;
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (rel[b]) begin
                        limit = last_release[b] + dbl_window;
                        dbl[b] = tk.time_ms < limit;
                        last_release[b] = tk.time_ms;
                    end
                    if (tk.buttons_now[b]) begin
                        rects[b].end_x = tk.pointer_x;
                        rects[b].end_y = tk.pointer_y;
                    end
                    if (press[b]) begin
                        rects[b].start_x = tk.pointer_x;
                        rects[b].start_y = tk.pointer_y;
                    end
                end
                flags = {dbl, rel, press, tk.buttons_now};
            end
            rep = '0;
            rep.flags = flags;
            rep.left = rects[0];
            rep.middle = rects[1];
            rep.right = rects[2];
            expected_reports.push_back(rep);
        endfunction

        function void check_field(string name, logic [RECT_W-1:0] want, logic [RECT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_report(logic [OUT_W-1:0] beat);
            t_report got;
            t_report want;
            got = beat;
            if (expected_reports.size() == 0) begin
                $error("result beat with no tick outstanding: %h", beat);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            check_field("button_flags", RECT_W'(want.flags), RECT_W'(got.flags));
            check_field("left_drag_rect", want.left, got.left);
            check_field("middle_drag_rect", want.middle, got.middle);
            check_field("right_drag_rect", want.right, got.right);
            check_field("pad", RECT_W'(want.pad), RECT_W'(got.pad));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;

    click_tracker_board board = new();
    int quiet_cycles = 0;
    int reports_taken = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    logic [NUM_BUTTONS-1:0] levels_now = '0;

    mouse_button_click_tracker_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic t_tick mk_tick(logic act, logic [COORD_BITS-1:0] px,
                                      logic [COORD_BITS-1:0] py,
                                      logic [NUM_BUTTONS-1:0] lv, logic [TIME_W-1:0] ms);
        t_tick tk;
        tk = '0;
        tk.window_active = act;
        tk.pointer_x = px;
        tk.pointer_y = py;
        tk.buttons_now = lv;
        tk.time_ms = ms;
        return tk;
    endfunction

    // Mostly plausible pointer activity inside the client area, with a share of
    // unfocused ticks, stray pointer positions and entirely random beats.
    function automatic t_tick next_tick();
        t_tick tk;
        int pick;
        int w;
        int h;
        logic [TIME_W-1:0] step;
        w = (int'(board.area_w) > 2048) ? 2048 : int'(board.area_w);
        h = (int'(board.area_h) > 2048) ? 2048 : int'(board.area_h);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            tk = '0;
            tk.window_active = 1'($urandom);
            tk.pointer_x = COORD_BITS'($urandom);
            tk.pointer_y = COORD_BITS'($urandom);
            tk.buttons_now = NUM_BUTTONS'($urandom);
            tk.time_ms = $urandom;
            return tk;
        end
        levels_now ^= NUM_BUTTONS'($urandom_range(0, 7) & $urandom_range(0, 7));
        if (board.dbl_window <= 5000) begin
            step = $urandom_range(0, board.dbl_window * 2 + 2);
        end else if ($urandom_range(0, 9) == 0) begin
            step = $urandom;
        end else begin
            step = $urandom_range(0, 3000);
        end
        clock_ms += step;
        tk = mk_tick(pick >= 14, COORD_BITS'((w > 0) ? $urandom_range(0, w - 1) : 0),
                     COORD_BITS'((h > 0) ? $urandom_range(0, h - 1) : 0), levels_now,
                     clock_ms);
        if (pick >= 14 && pick < 20) begin
            tk.pointer_x = COORD_BITS'($urandom);
            tk.pointer_y = COORD_BITS'($urandom);
        end
        return tk;
    endfunction

    task automatic send_tick(input t_tick tk, ref int calm_left);
        int gap;
        gap = draw_gap(calm_left);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= tk;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.absorb_tick(tk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [TIME_W-1:0] dbl_ms, input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h, input logic spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int n;
        idx[0] = CFG_DBL_MS;
        val[0] = dbl_ms;
        idx[1] = CFG_WIDTH;
        val[1] = w;
        idx[2] = CFG_HEIGHT;
        val[2] = h;
        idx[3] = CFG_SPARE;
        val[3] = $urandom;
        n = spare ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.write_reg(idx[i], val[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_tick opening [$];
        int calm_left;
        int items;
        logic [TIME_W-1:0] dbl_ms;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        calm_left = 0;
        opening.push_back(mk_tick(1'b0, 12'd0, 12'd0, 3'd7, 32'd0));
        opening.push_back(mk_tick(1'b1, 12'd0, 12'd0, 3'd7, 32'd10));
        opening.push_back(mk_tick(1'b1, 12'd1023, 12'd767, 3'd7, 32'd20));
        opening.push_back(mk_tick(1'b1, 12'd1024, 12'd5, 3'd0, 32'd30));
        opening.push_back(mk_tick(1'b1, 12'd5, 12'd768, 3'd0, 32'd40));
        opening.push_back(mk_tick(1'b1, 12'hFFF, 12'd0, 3'd0, 32'd50));
        opening.push_back(mk_tick(1'b1, 12'h800, 12'h7FF, 3'd0, 32'd60));
        opening.push_back(mk_tick(1'b1, 12'h7FF, 12'h800, 3'd0, 32'd70));
        opening.push_back(mk_tick(1'b1, 12'd100, 12'd200, 3'd0, 32'd100));
        opening.push_back(mk_tick(1'b1, 12'd100, 12'd200, 3'd1, 32'd200));
        opening.push_back(mk_tick(1'b1, 12'd300, 12'd400, 3'd1, 32'd250));
        opening.push_back(mk_tick(1'b1, 12'd300, 12'd400, 3'd0, 32'd400));
        opening.push_back(mk_tick(1'b1, 12'd10, 12'd10, 3'd1, 32'd1000));
        opening.push_back(mk_tick(1'b1, 12'd10, 12'd10, 3'd0, 32'd1000));
        opening.push_back(mk_tick(1'b1, 12'd20, 12'd30, 3'd2, 32'hFFFF_FE00));
        opening.push_back(mk_tick(1'b1, 12'd20, 12'd30, 3'd0, 32'hFFFF_FF00));
        opening.push_back(mk_tick(1'b1, 12'd40, 12'd50, 3'd2, 32'hFFFF_FF80));
        opening.push_back(mk_tick(1'b1, 12'd40, 12'd50, 3'd0, 32'h0000_0010));
        opening.push_back(mk_tick(1'b1, 12'd1023, 12'd0, 3'd4, 32'h0000_0020));
        opening.push_back(mk_tick(1'b0, 12'd1023, 12'd0, 3'd0, 32'h0000_0030));
        opening.push_back(mk_tick(1'b1, 12'd0, 12'd767, 3'd4, 32'h0000_0040));
        opening.push_back(mk_tick(1'b1, 12'd0, 12'd767, 3'd0, 32'hFFFF_FFFF));
        opening.push_back(mk_tick(1'b1, 12'd512, 12'd384, 3'd6, 32'h0000_0100));
        opening.push_back(mk_tick(1'b1, 12'd512, 12'd384, 3'd0, 32'h0000_01F0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening[i]) send_tick(opening[i], calm_left);
        drain();

        for (int p = 0; p < 6; p++) begin
            items = PHASE_ITEMS;
            case (p)
                0: begin
                    dbl_ms = 32'd0;
                    w = 32'd2048;
                    h = 32'd2048;
                end
                1: begin
                    dbl_ms = 32'hFFFF_FFFF;
                    w = 32'd1;
                    h = 32'd1;
                end
                2: begin
                    dbl_ms = 32'd300;
                    w = 32'd640;
                    h = 32'd480;
                end
                3: begin
                    dbl_ms = 32'd1000;
                    w = 32'd0;
                    h = 32'd300;
                    items = NO_AREA_ITEMS;
                end
                4: begin
                    dbl_ms = $urandom_range(0, 2000);
                    w = $urandom_range(1, 2048);
                    h = $urandom_range(1, 2048);
                end
                default: begin
                    dbl_ms = 32'd500;
                    w = 32'd100;
                    h = 32'hFFF;
                end
            endcase
            configure(dbl_ms, w, h, p == 2);
            clock_ms = (p == 1) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
            repeat (items) send_tick(next_tick(), calm_left);
            drain();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // The result side sometimes holds off for a long stretch so that the tick
    // side backs up and has to stall.
    initial begin : result_sink
        int stall;
        int calm_left;
        calm_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap(calm_left);
            if (reports_taken == 150 || reports_taken == 450) begin
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            board.compare_report(o_m_axis_tdata);
            reports_taken++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mbct_pkg.sv
hw/rtl/mouse_button_click_tracker_core.sv
hw/rtl/mbct_checker.sv
tb/sv/tb_top.sv
